// ===== rtl/monotone_line_envelope_top_defines.svh =====
// Assertion macros shared by the checker file.
// Every macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef MONOTONE_LINE_ENVELOPE_TOP_DEFINES_SVH
`define MONOTONE_LINE_ENVELOPE_TOP_DEFINES_SVH

// Same-cycle implication.
`define MLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mle_pkg.sv =====
// ----------------------------------------------------------------------------
// mle_pkg
// Shared codes and types for the monotone line envelope block.
// ----------------------------------------------------------------------------
`default_nettype none

package mle_pkg;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic CFG_OPTIMIZE_MAX = 1'b0;
  localparam logic CFG_QUERY_WALK   = 1'b1;

  localparam logic [2:0] STATUS_ADDED     = 3'd0;
  localparam logic [2:0] STATUS_REDUNDANT = 3'd1;
  localparam logic [2:0] STATUS_ORDER     = 3'd2;
  localparam logic [2:0] STATUS_FULL      = 3'd3;
  localparam logic [2:0] STATUS_QUERY_OK  = 3'd4;
  localparam logic [2:0] STATUS_EMPTY     = 3'd5;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TOP_RD,
    S_TOP,
    S_POP_CHK,
    S_POP_RD,
    S_POP_L1,
    S_MUL_L,
    S_MUL_R,
    S_POP_CMP,
    S_PUSH,
    S_Q_CHK,
    S_PAIR_A,
    S_PAIR_B,
    S_PAIR_E,
    S_PAIR_CMP,
    S_FIN_RD,
    S_FIN_A,
    S_FIN_OUT,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/mle_ram.sv =====
// ----------------------------------------------------------------------------
// mle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mle_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/mle_mac.sv =====
// ----------------------------------------------------------------------------
// mle_mac
// Shared signed multiply-add with a registered result: q = a*b + addend.
// ----------------------------------------------------------------------------
`default_nettype none

module mle_mac #(
  parameter int OW = 33
) (
  input  wire logic                    clk,
  input  wire logic signed [OW-1:0]    a,
  input  wire logic signed [OW-1:0]    b,
  input  wire logic signed [2*OW-1:0]  addend,
  output logic      signed [2*OW-1:0]  q_r
);

  logic signed [2*OW-1:0] prod;

  assign prod = a * b;

  always_ff @(posedge clk) begin
    q_r <= prod + addend;
  end

endmodule

`default_nettype wire

// ===== rtl/monotone_line_envelope_top.sv =====
// ----------------------------------------------------------------------------
// monotone_line_envelope_top
// Line stack for the convex hull trick with monotone slopes: add and query.
// ----------------------------------------------------------------------------
// Add: rejects an out-of-order slope or a no-better same-slope line, replaces a
//   worse same-slope top, pops lines hidden by the cross-product test, then pushes.
// Query: binary search over adjacent line pairs, or a walk pointer that advances
//   from its saved place while the next line is better.
// Every item then presents its result until it is taken; one at a time.
// Reset (synchronous, rst_n low) empties the stack, zeroes walk pointer and config.
`default_nettype none

module monotone_line_envelope_top #(
  parameter int DEPTH      = 1024,
  parameter int COORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_mode,
  input  wire logic [31:0] in_slope,
  input  wire logic [31:0] in_intercept,
  input  wire logic [31:0] in_query_x,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_best_value,
  output logic [31:0]      out_best_slope,
  output logic [31:0]      out_best_intercept,
  output logic [2:0]       out_status,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic        cfg_data
);

  localparam int CW = COORD_BITS;
  localparam int AW = $clog2(DEPTH);
  localparam int PW = 2 * (CW + 1);

  function automatic logic signed [CW:0] ext1(input logic signed [CW-1:0] v);
    return {v[CW-1], v};
  endfunction

  // Control state
  mle_pkg::state_t state_r, state_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]   walk_r, walk_nxt;
  logic            omax_r, qwalk_r;

  // Working payload
  logic signed [CW-1:0] s_r, s_nxt, c_r, c_nxt, x_r, x_nxt;
  logic [AW:0]          n_r, n_nxt;
  logic signed [CW-1:0] l1s_r, l1s_nxt, l1c_r, l1c_nxt;
  logic signed [CW-1:0] l2s_r, l2s_nxt, l2c_r, l2c_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic signed [AW+1:0] ok_r, ok_nxt, ng_r, ng_nxt;
  logic signed [PW-1:0] val_r, val_nxt;
  logic signed [CW-1:0] os_r, os_nxt, oc_r, oc_nxt;
  logic [2:0]           st_r, st_nxt;

  // RAM and shared unit
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [2*CW-1:0]      ram_rdata;
  logic signed [CW-1:0] rd_s, rd_c;
  logic signed [CW:0]   mac_a, mac_b;
  logic signed [PW-1:0] mac_add, mac_q;

  logic signed [AW+1:0] bs_sum, bs_gap;
  logic [AW-1:0]        bs_mid;
  logic [AW:0]          idx_inc;
  logic signed [63+PW:0] val_ext;
  logic signed [CW+31:0] os_ext, oc_ext;

  function automatic logic better_c(input logic signed [CW-1:0] a,
                                    input logic signed [CW-1:0] b);
    return omax_r ? (a > b) : (a < b);
  endfunction

  function automatic logic better_v(input logic signed [PW-1:0] a,
                                    input logic signed [PW-1:0] b);
    return omax_r ? (a > b) : (a < b);
  endfunction

  assign rd_s    = ram_rdata[2*CW-1:CW];
  assign rd_c    = ram_rdata[CW-1:0];
  assign bs_sum  = ok_r + ng_r;
  assign bs_gap  = ok_r - ng_r;
  assign bs_mid  = bs_sum[AW:1];
  assign idx_inc = (AW+1)'(idx_r) + (AW+1)'(1);

  mle_ram #(
    .WIDTH(2 * CW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({s_r, c_r}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  mle_mac #(
    .OW(CW + 1)
  ) u_mac (
    .clk   (clk),
    .a     (mac_a),
    .b     (mac_b),
    .addend(mac_add),
    .q_r   (mac_q)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mle_pkg::S_IDLE;
      cnt_r   <= '0;
      walk_r  <= '0;
      omax_r  <= 1'b0;
      qwalk_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      walk_r  <= walk_nxt;
      if (cfg_we && cfg_index == mle_pkg::CFG_OPTIMIZE_MAX) begin
        omax_r <= cfg_data;
      end
      if (cfg_we && cfg_index == mle_pkg::CFG_QUERY_WALK) begin
        qwalk_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    c_r    <= c_nxt;
    x_r    <= x_nxt;
    n_r    <= n_nxt;
    l1s_r  <= l1s_nxt;
    l1c_r  <= l1c_nxt;
    l2s_r  <= l2s_nxt;
    l2c_r  <= l2c_nxt;
    prod_r <= prod_nxt;
    idx_r  <= idx_nxt;
    ok_r   <= ok_nxt;
    ng_r   <= ng_nxt;
    val_r  <= val_nxt;
    os_r   <= os_nxt;
    oc_r   <= oc_nxt;
    st_r   <= st_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    walk_nxt  = walk_r;
    s_nxt     = s_r;
    c_nxt     = c_r;
    x_nxt     = x_r;
    n_nxt     = n_r;
    l1s_nxt   = l1s_r;
    l1c_nxt   = l1c_r;
    l2s_nxt   = l2s_r;
    l2c_nxt   = l2c_r;
    prod_nxt  = prod_r;
    idx_nxt   = idx_r;
    ok_nxt    = ok_r;
    ng_nxt    = ng_r;
    val_nxt   = val_r;
    os_nxt    = os_r;
    oc_nxt    = oc_r;
    st_nxt    = st_r;
    ram_we    = 1'b0;
    ram_waddr = n_r[AW-1:0];
    ram_raddr = idx_r;
    mac_a     = '0;
    mac_b     = '0;
    mac_add   = '0;

    case (state_r)
      mle_pkg::S_IDLE: begin
        if (in_valid) begin
          s_nxt   = in_slope[CW-1:0];
          c_nxt   = in_intercept[CW-1:0];
          x_nxt   = in_query_x[CW-1:0];
          n_nxt   = cnt_r;
          val_nxt = '0;
          os_nxt  = '0;
          oc_nxt  = '0;
          if (in_mode == mle_pkg::MODE_ADD) begin
            state_nxt = (cnt_r == '0) ? mle_pkg::S_PUSH : mle_pkg::S_TOP_RD;
          end else if (cnt_r == '0) begin
            st_nxt    = mle_pkg::STATUS_EMPTY;
            state_nxt = mle_pkg::S_OUT;
          end else begin
            // clamp the walk pointer to the last line
            idx_nxt   = ((AW+1)'(walk_r) >= cnt_r) ? AW'(cnt_r - 1'b1) : walk_r;
            ok_nxt    = (AW+2)'(cnt_r) - (AW+2)'(1);
            ng_nxt    = '1;
            state_nxt = mle_pkg::S_Q_CHK;
          end
        end
      end

      mle_pkg::S_TOP_RD: begin
        ram_raddr = AW'(n_r - 1'b1);
        state_nxt = mle_pkg::S_TOP;
      end

      mle_pkg::S_TOP: begin
        if (better_c(rd_s, s_r)) begin
          st_nxt    = mle_pkg::STATUS_ORDER;
          state_nxt = mle_pkg::S_OUT;
        end else if (rd_s == s_r) begin
          if (!better_c(c_r, rd_c)) begin
            st_nxt    = mle_pkg::STATUS_REDUNDANT;
            state_nxt = mle_pkg::S_OUT;
          end else begin
            // replace the same-slope top
            n_nxt     = n_r - 1'b1;
            state_nxt = mle_pkg::S_POP_CHK;
          end
        end else begin
          state_nxt = mle_pkg::S_POP_CHK;
        end
      end

      mle_pkg::S_POP_CHK: begin
        ram_raddr = AW'(n_r - 1'b1);
        state_nxt = (n_r >= (AW+1)'(2)) ? mle_pkg::S_POP_RD : mle_pkg::S_PUSH;
      end

      mle_pkg::S_POP_RD: begin
        ram_raddr = AW'(n_r - (AW+1)'(2));
        l2s_nxt   = rd_s;
        l2c_nxt   = rd_c;
        state_nxt = mle_pkg::S_POP_L1;
      end

      mle_pkg::S_POP_L1: begin
        l1s_nxt = rd_s;
        l1c_nxt = rd_c;
        if (l2s_r == s_r) begin
          n_nxt     = n_r - 1'b1;
          state_nxt = mle_pkg::S_POP_CHK;
        end else begin
          state_nxt = mle_pkg::S_MUL_L;
        end
      end

      mle_pkg::S_MUL_L: begin
        mac_a     = ext1(l2s_r) - ext1(l1s_r);
        mac_b     = ext1(c_r) - ext1(l2c_r);
        state_nxt = mle_pkg::S_MUL_R;
      end

      mle_pkg::S_MUL_R: begin
        prod_nxt  = mac_q;
        mac_a     = ext1(s_r) - ext1(l2s_r);
        mac_b     = ext1(l2c_r) - ext1(l1c_r);
        state_nxt = mle_pkg::S_POP_CMP;
      end

      mle_pkg::S_POP_CMP: begin
        if (prod_r >= mac_q) begin
          n_nxt     = n_r - 1'b1;
          state_nxt = mle_pkg::S_POP_CHK;
        end else begin
          state_nxt = mle_pkg::S_PUSH;
        end
      end

      mle_pkg::S_PUSH: begin
        if (n_r >= (AW+1)'(DEPTH)) begin
          st_nxt = mle_pkg::STATUS_FULL;
        end else begin
          ram_we  = 1'b1;
          cnt_nxt = n_r + 1'b1;
          st_nxt  = mle_pkg::STATUS_ADDED;
        end
        state_nxt = mle_pkg::S_OUT;
      end

      mle_pkg::S_Q_CHK: begin
        if (qwalk_r) begin
          ram_raddr = idx_r;
          state_nxt = (idx_inc < cnt_r) ? mle_pkg::S_PAIR_A : mle_pkg::S_FIN_RD;
        end else if (bs_gap > (AW+2)'(1)) begin
          ram_raddr = bs_mid;
          idx_nxt   = bs_mid;
          state_nxt = mle_pkg::S_PAIR_A;
        end else begin
          idx_nxt   = ok_r[AW-1:0];
          state_nxt = mle_pkg::S_FIN_RD;
        end
      end

      mle_pkg::S_PAIR_A: begin
        ram_raddr = idx_inc[AW-1:0];
        l1s_nxt   = rd_s;
        l1c_nxt   = rd_c;
        state_nxt = mle_pkg::S_PAIR_B;
      end

      mle_pkg::S_PAIR_B: begin
        l2s_nxt   = rd_s;
        l2c_nxt   = rd_c;
        mac_a     = ext1(l1s_r);
        mac_b     = ext1(x_r);
        mac_add   = PW'(l1c_r);
        state_nxt = mle_pkg::S_PAIR_E;
      end

      mle_pkg::S_PAIR_E: begin
        prod_nxt  = mac_q;
        mac_a     = ext1(l2s_r);
        mac_b     = ext1(x_r);
        mac_add   = PW'(l2c_r);
        state_nxt = mle_pkg::S_PAIR_CMP;
      end

      mle_pkg::S_PAIR_CMP: begin
        if (qwalk_r) begin
          if (better_v(mac_q, prod_r)) begin
            idx_nxt   = idx_inc[AW-1:0];
            state_nxt = mle_pkg::S_Q_CHK;
          end else begin
            // current line stays best: finish from the pair
            walk_nxt  = idx_r;
            val_nxt   = prod_r;
            os_nxt    = l1s_r;
            oc_nxt    = l1c_r;
            st_nxt    = mle_pkg::STATUS_QUERY_OK;
            state_nxt = mle_pkg::S_OUT;
          end
        end else begin
          if (better_v(prod_r, mac_q)) begin
            ok_nxt = (AW+2)'(idx_r);
          end else begin
            ng_nxt = (AW+2)'(idx_r);
          end
          state_nxt = mle_pkg::S_Q_CHK;
        end
      end

      mle_pkg::S_FIN_RD: begin
        ram_raddr = idx_r;
        state_nxt = mle_pkg::S_FIN_A;
      end

      mle_pkg::S_FIN_A: begin
        l1s_nxt   = rd_s;
        l1c_nxt   = rd_c;
        mac_a     = ext1(rd_s);
        mac_b     = ext1(x_r);
        mac_add   = PW'(rd_c);
        state_nxt = mle_pkg::S_FIN_OUT;
      end

      mle_pkg::S_FIN_OUT: begin
        if (qwalk_r) begin
          walk_nxt = idx_r;
        end
        val_nxt   = mac_q;
        os_nxt    = l1s_r;
        oc_nxt    = l1c_r;
        st_nxt    = mle_pkg::STATUS_QUERY_OK;
        state_nxt = mle_pkg::S_OUT;
      end

      mle_pkg::S_OUT: begin
        // hold the result until the transfer
        if (!out_stall) begin
          state_nxt = mle_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = mle_pkg::S_IDLE;
      end
    endcase
  end

  assign val_ext = {{64{val_r[PW-1]}}, val_r};
  assign os_ext  = {{32{os_r[CW-1]}}, os_r};
  assign oc_ext  = {{32{oc_r[CW-1]}}, oc_r};

  assign in_stall           = (state_r != mle_pkg::S_IDLE);
  assign out_valid          = (state_r == mle_pkg::S_OUT);
  assign out_best_value     = val_ext[63:0];
  assign out_best_slope     = os_ext[31:0];
  assign out_best_intercept = oc_ext[31:0];
  assign out_status         = st_r;

endmodule

`default_nettype wire

// ===== rtl/mle_checker.sv =====
// ----------------------------------------------------------------------------
// mle_checker
// Port-level checks of the line envelope block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "monotone_line_envelope_top_defines.svh"

module mle_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_best_value,
  input wire logic [31:0] out_best_slope,
  input wire logic [2:0]  out_status
);

  `MLE_ASSERT_NOW(a_busy_while_result, out_valid, in_stall, "input taken while result pending")

  `MLE_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "second item taken at once")

  `MLE_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid && $stable(out_status), "stalled result changed")

  `MLE_ASSERT_NOW(a_zero_fields, out_valid && out_status != mle_pkg::STATUS_QUERY_OK, out_best_value == 64'd0 && out_best_slope == 32'd0, "nonzero fields on non-query result")

endmodule

bind monotone_line_envelope_top mle_checker u_mle_checker (.*);

`default_nettype wire

// ===== bench/tb_monotone_line_envelope_top.sv =====
// ----------------------------------------------------------------------------
// tb_monotone_line_envelope_top
// Self-checking bench for the monotone line envelope block.
// A queue-fed driver sends add and query transfers in random bursts. A
// predictor holds its own line stack and computes each expected result as the
// transfer is taken. A monitor checks every result field against the oldest
// expectation. Phases cover both envelope kinds, both query searches, a fill
// of the whole store and random monotone line sequences with broken ones mixed in.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_monotone_line_envelope_top;

  localparam int DEPTH      = 1024;
  localparam int IDLE_LIMIT = 40000;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct {
    logic        mode;
    logic [31:0] slope;
    logic [31:0] intercept;
    logic [31:0] query_x;
  } line_req_t;

  typedef struct {
    logic [63:0] value;
    logic [31:0] slope;
    logic [31:0] intercept;
    logic [2:0]  status;
  } envelope_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = mle_pkg::MODE_ADD;
  logic [31:0] in_slope = '0;
  logic [31:0] in_intercept = '0;
  logic [31:0] in_query_x = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_best_value;
  logic [31:0] out_best_slope;
  logic [31:0] out_best_intercept;
  logic [2:0]  out_status;
  logic        cfg_we = 1'b0;
  logic        cfg_index = mle_pkg::CFG_OPTIMIZE_MAX;
  logic        cfg_data = 1'b0;

  monotone_line_envelope_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_slope(in_slope), .in_intercept(in_intercept), .in_query_x(in_query_x),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_best_value(out_best_value), .out_best_slope(out_best_slope),
    .out_best_intercept(out_best_intercept), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state: the line stack and the two mode bits.
  longint stack_slope [DEPTH];
  longint stack_icpt  [DEPTH];
  int     stack_depth = 0;
  int     walk_ptr = 0;
  bit     keep_max = 1'b0;
  bit     walk_mode = 1'b0;

  line_req_t     pending_lines[$];
  envelope_res_t expected_results[$];
  line_req_t     held;
  int            items_queued = 0;
  int            results_seen = 0;
  int            errors = 0;

  function automatic bit beats(longint a, longint b);
    return keep_max ? (a > b) : (a < b);
  endfunction

  // Exact cross-product test: the middle line never wins between its neighbors.
  function automatic bit is_hidden(longint s1, longint c1, longint s2, longint c2,
                                   longint s3, longint c3);
    logic signed [127:0] ls, lc, rs, rc;
    if (s2 == s3) return 1'b1;
    ls = s2 - s1;
    lc = c3 - c2;
    rs = s3 - s2;
    rc = c2 - c1;
    return (ls * lc) >= (rs * rc);
  endfunction

  function automatic longint line_at(int i, longint x);
    return stack_slope[i] * x + stack_icpt[i];
  endfunction

  function automatic envelope_res_t envelope_step(line_req_t req);
    envelope_res_t r;
    longint s, c, x;
    int n, ok, ng, mid, h, best;
    r = '{value: '0, slope: '0, intercept: '0, status: mle_pkg::STATUS_ADDED};
    n = stack_depth;
    if (req.mode == mle_pkg::MODE_ADD) begin
      s = longint'(signed'(req.slope));
      c = longint'(signed'(req.intercept));
      if (n > 0) begin
        if (beats(stack_slope[n-1], s)) begin
          r.status = mle_pkg::STATUS_ORDER;
          return r;
        end
        if (stack_slope[n-1] == s) begin
          if (!beats(c, stack_icpt[n-1])) begin
            r.status = mle_pkg::STATUS_REDUNDANT;
            return r;
          end
          n--;
        end
      end
      while (n >= 2 && is_hidden(stack_slope[n-2], stack_icpt[n-2],
                                 stack_slope[n-1], stack_icpt[n-1], s, c))
        n--;
      if (n >= DEPTH) begin
        r.status = mle_pkg::STATUS_FULL;
        return r;
      end
      stack_slope[n] = s;
      stack_icpt[n] = c;
      stack_depth = n + 1;
      return r;
    end
    x = longint'(signed'(req.query_x));
    if (n == 0) begin
      r.status = mle_pkg::STATUS_EMPTY;
      return r;
    end
    if (walk_mode) begin
      h = (walk_ptr >= n) ? n - 1 : walk_ptr;
      while (h + 1 < n && beats(line_at(h + 1, x), line_at(h, x)))
        h++;
      walk_ptr = h;
      best = h;
    end else begin
      ok = n - 1;
      ng = -1;
      while (ok - ng > 1) begin
        mid = (ok + ng) / 2;
        if (beats(line_at(mid, x), line_at(mid + 1, x))) ok = mid;
        else ng = mid;
      end
      best = ok;
    end
    r.value = line_at(best, x);
    r.slope = stack_slope[best][31:0];
    r.intercept = stack_icpt[best][31:0];
    r.status = mle_pkg::STATUS_QUERY_OK;
    return r;
  endfunction

  // Driver: bursts of transfers with random gaps; predict on each transfer.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(envelope_step(held));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_lines.size() > 0) begin
          held = pending_lines.pop_front();
          in_mode <= held.mode;
          in_slope <= held.slope;
          in_intercept <= held.intercept;
          in_query_x <= held.query_x;
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: stall_tick paces random switches of the stall density.
  int stall_pct = 0;
  int stall_tick = 0;

  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 50 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Monitor: compare each result transfer with the oldest expectation.
  envelope_res_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status %0d", $time, out_status);
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
        end
        if (out_best_value !== want.value) begin
          errors++;
          $display("%0t: best_value expected %0d actual %0d", $time,
                   signed'(want.value), signed'(out_best_value));
        end
        if (out_best_slope !== want.slope) begin
          errors++;
          $display("%0t: best_slope expected %0d actual %0d", $time,
                   signed'(want.slope), signed'(out_best_slope));
        end
        if (out_best_intercept !== want.intercept) begin
          errors++;
          $display("%0t: best_intercept expected %0d actual %0d", $time,
                   signed'(want.intercept), signed'(out_best_intercept));
        end
      end
    end
  end

  // Watchdog: count cycles with outstanding work and no transfer on either side.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || items_queued == results_seen)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic longint clamp32(longint v);
    return (v > S32_MAX) ? S32_MAX : ((v < S32_MIN) ? S32_MIN : v);
  endfunction

  task automatic push_line(logic mode, longint s, longint c, longint x);
    line_req_t req;
    req.mode = mode;
    req.slope = s[31:0];
    req.intercept = c[31:0];
    req.query_x = x[31:0];
    pending_lines.push_back(req);
    items_queued++;
  endtask

  task automatic wait_idle();
    while (items_queued != results_seen) @(posedge clk);
  endtask

  // Write both mode bits once every result is back.
  task automatic set_modes(bit mx, bit wk);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= mle_pkg::CFG_OPTIMIZE_MAX;
    cfg_data <= mx;
    keep_max = mx;
    @(posedge clk);
    cfg_index <= mle_pkg::CFG_QUERY_WALK;
    cfg_data <= wk;
    walk_mode = wk;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Monotone slopes drifting from the current stack top, with out-of-order and
  // same-slope adds and queries mixed in.
  task automatic random_phase(bit mx, bit wk, int count);
    longint base, dir, s, c, x, walk_x;
    int r;
    set_modes(mx, wk);
    base = (stack_depth > 0) ? stack_slope[stack_depth-1] : longint'(signed'($urandom));
    dir = mx ? 1 : -1;
    walk_x = longint'(signed'($urandom)) >>> 4;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      c = ($urandom_range(0, 3) == 0) ? longint'(signed'($urandom))
                                      : longint'($urandom_range(0, 40000)) - 20000;
      if (r < 35) begin
        if (wk && r < 30) begin
          walk_x = clamp32(walk_x + $urandom_range(0, 60));
          if ($urandom_range(0, 40) == 0) walk_x = longint'(signed'($urandom));
          x = walk_x;
        end else if (r < 20) begin
          x = longint'(signed'($urandom));
        end else begin
          x = longint'($urandom_range(0, 2000)) - 1000;
        end
        push_line(mle_pkg::MODE_QUERY, longint'(signed'($urandom)), c, x);
      end else begin
        if (r < 42) begin
          s = clamp32(base - dir * $urandom_range(1, 1000));
        end else if (r < 48) begin
          s = base;
        end else begin
          base = clamp32(base + dir * (($urandom_range(0, 9) < 8) ? $urandom_range(0, 40)
                                                                  : $urandom_range(0, 1 << 20)));
          s = base;
        end
        push_line(mle_pkg::MODE_ADD, s, c, longint'(signed'($urandom)));
      end
    end
  endtask

  // Tangents of a parabola all stay on the envelope, so the store fills up.
  task automatic fill_store();
    longint s0, dir;
    bit mx;
    wait_idle();
    s0 = (stack_depth > 0) ? stack_slope[stack_depth-1] : 0;
    mx = (s0 < 0);
    dir = mx ? 1 : -1;
    set_modes(mx, 1'b0);
    for (int i = 0; i < DEPTH + 6; i++)
      push_line(mle_pkg::MODE_ADD, s0 + dir * 2 * i, -dir * i * i, 0);
    for (int i = 0; i < 8; i++)
      push_line(mle_pkg::MODE_QUERY, 0, 0,
                longint'(signed'($urandom)) >>> $urandom_range(0, 31));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: minimum envelope, binary search.
    push_line(mle_pkg::MODE_QUERY, 0, 0, 0);              // empty stack
    push_line(mle_pkg::MODE_ADD, 0, 0, 0);
    push_line(mle_pkg::MODE_ADD, 0, 5, 0);                // same slope, worse
    push_line(mle_pkg::MODE_ADD, 0, -5, 0);               // same slope, better
    push_line(mle_pkg::MODE_ADD, 1, 0, 0);                // slope out of order
    push_line(mle_pkg::MODE_ADD, -3, 7, 0);
    push_line(mle_pkg::MODE_ADD, -100, S32_MAX, 0);
    push_line(mle_pkg::MODE_ADD, S32_MIN, S32_MIN, 0);
    push_line(mle_pkg::MODE_ADD, S32_MIN, S32_MAX, 0);    // worse at extreme slope
    push_line(mle_pkg::MODE_QUERY, 0, 0, 0);
    push_line(mle_pkg::MODE_QUERY, 0, 0, S32_MAX);
    push_line(mle_pkg::MODE_QUERY, 0, 0, S32_MIN);
    push_line(mle_pkg::MODE_QUERY, 0, 0, 1);
    push_line(mle_pkg::MODE_QUERY, 0, 0, -1);

    // Directed: maximum envelope, walking pointer.
    set_modes(1'b1, 1'b1);
    push_line(mle_pkg::MODE_ADD, 5, S32_MIN, 0);
    push_line(mle_pkg::MODE_ADD, 4, 0, 0);                // out of order for max
    push_line(mle_pkg::MODE_ADD, S32_MAX, S32_MAX, 0);
    push_line(mle_pkg::MODE_ADD, S32_MAX, -1, 0);         // worse for max
    push_line(mle_pkg::MODE_QUERY, 0, 0, S32_MIN);
    push_line(mle_pkg::MODE_QUERY, 0, 0, -7);
    push_line(mle_pkg::MODE_QUERY, 0, 0, 0);
    push_line(mle_pkg::MODE_QUERY, 0, 0, S32_MAX);
    push_line(mle_pkg::MODE_QUERY, 0, 0, S32_MIN);        // pointer stays ahead

    random_phase(1'b0, 1'b0, 220);
    random_phase(1'b1, 1'b1, 220);
    fill_store();
    random_phase(1'b0, 1'b1, 220);
    random_phase(1'b1, 1'b0, 230);

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/mle_pkg.sv
rtl/mle_ram.sv
rtl/mle_mac.sv
rtl/monotone_line_envelope_top.sv
rtl/mle_checker.sv
bench/tb_monotone_line_envelope_top.sv
